@@ design/cets_pkg.sv @@
// ----------------------------------------------------------------------------
// cets_pkg: shared types, constants and lookup functions
// Item types for both channels, the command passed from the classifier to
// the sequencer, and the character and special key tables.
// ----------------------------------------------------------------------------
package cets_pkg;

  localparam logic [7:0] EV_PRESS = 8'd1;
  localparam logic [7:0] EV_HOLD  = 8'd2;

  localparam logic [7:0] KC_PRINT_LO = 8'h20;
  localparam logic [7:0] KC_PRINT_HI = 8'h7f;   // first code past the printable range
  localparam logic [7:0] KC_LSHIFT   = 8'ha2;
  localparam logic [7:0] KC_RSHIFT   = 8'ha3;
  localparam logic [7:0] KC_FKEY_LO  = 8'h81;
  localparam logic [7:0] KC_FKEY_HI  = 8'h8a;

  localparam logic [6:0] SC_SHIFT   = 7'h2a;
  localparam logic [6:0] SC_F1      = 7'h3b;
  localparam int         CHAR_COUNT = 95;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_LAST  = 2'd2;

  typedef struct packed {
    logic [7:0] event_state;
    logic [7:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic       key_down;
    logic [6:0] out_keycode;
    logic       last_of_run;
  } out_item_t;

  // One classified event: either a single key result or a shift-wrapped run.
  typedef struct packed {
    logic       wrap;
    logic       need;
    logic       restore;
    logic       down;
    logic [6:0] scancode;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] phase;
  } bk_status_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] code;
  } special_t;

  // Bit 7 marks a character that needs shift, bits 6:0 are the set-1 scancode.
  localparam logic [7:0] CHAR_MAP [0:CHAR_COUNT-1] = '{
    8'h39, 8'h82, 8'ha8, 8'h84, 8'h85, 8'h86, 8'h88, 8'h28,
    8'h8a, 8'h8b, 8'h89, 8'h8d, 8'h33, 8'h0c, 8'h34, 8'h35,
    8'h0b, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'ha7, 8'h27, 8'hb3, 8'h0d, 8'hb4, 8'hb5, 8'h83,
    8'h9e, 8'hb0, 8'hae, 8'ha0, 8'h92, 8'ha1, 8'ha2,
    8'ha3, 8'h97, 8'ha4, 8'ha5, 8'ha6, 8'hb2,
    8'hb1, 8'h98, 8'h99, 8'h90, 8'h93, 8'h9f, 8'h94,
    8'h96, 8'haf, 8'h91, 8'had, 8'h95, 8'hac,
    8'h1a, 8'h2b, 8'h1b, 8'h87, 8'h8c, 8'h29,
    8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
    8'h25, 8'h26, 8'h32,
    8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11,
    8'h2d, 8'h15, 8'h2c,
    8'h9a, 8'hab, 8'h9b, 8'ha9
  };

  function automatic logic [7:0] char_entry(input logic [6:0] idx);
    logic [7:0] e;
    e = 8'h00;
    if (int'(idx) < CHAR_COUNT) begin
      e = CHAR_MAP[idx];
    end
    return e;
  endfunction

  // Non-printable codes: fixed scancodes, F-keys and grey-block keycodes.
  function automatic special_t map_special(input logic [7:0] c);
    special_t r;
    logic [7:0] fk;
    r  = '{ok: 1'b1, code: 7'd0};
    fk = c - KC_FKEY_LO;
    unique case (c)
      8'h08:   r.code = 7'h0e;
      8'h09:   r.code = 7'h0f;
      8'h0a:   r.code = 7'h1c;
      8'h0d:   r.code = 7'h1c;
      8'hb1:   r.code = 7'h01;
      8'ha1:   r.code = 7'h38;
      8'ha2:   r.code = SC_SHIFT;
      8'ha3:   r.code = SC_SHIFT;
      8'ha5:   r.code = 7'h1d;
      8'hd0:   r.code = 7'h46;
      8'h90:   r.code = SC_F1 + 7'd9;
      8'hb5:   r.code = 7'd103;
      8'hb6:   r.code = 7'd108;
      8'hb4:   r.code = 7'd105;
      8'hb7:   r.code = 7'd106;
      8'hd2:   r.code = 7'd102;
      8'hd5:   r.code = 7'd107;
      8'hd6:   r.code = 7'd104;
      8'hd7:   r.code = 7'd109;
      8'hd1:   r.code = 7'd110;
      8'hd4:   r.code = 7'd111;
      default: begin
        if (c >= KC_FKEY_LO && c <= KC_FKEY_HI) begin
          r.code = SC_F1 + fk[6:0];
        end else begin
          r.ok = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

@@ design/char_event_to_scancode_translator_unit.sv @@
// ----------------------------------------------------------------------------
// char_event_to_scancode_translator_unit: character event to scancode block
// Turns keyboard character events into US set-1 key make and break items.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_ready, in_item) takes one event per
// item, an event state (1 press, 2 hold, anything else release) and a
// character or special key code. The result channel (out_valid, out_ready,
// out_item) delivers key items with a make or break flag, a 7-bit keycode
// and a flag that marks the final item of the event's run.
// A pressed or held printable character whose shift need differs from the
// tracked shift state yields three items (shift, key, shift restored); other
// kept events yield one item, and dropped codes yield none.
// An accepted item passes through a queue entry and the sequencer's command
// register before its first result reaches the output register. While
// out_ready stays high, the sequencer emits one result per cycle, and
// single-result events stream at one per cycle. A two-entry command queue
// between the classifier and the sequencer lets the input keep flowing while
// the sequencer works through a wrapped run or while the receiver stalls.
// When the receiver holds out_ready low, the output register holds its item,
// the queue fills, and in_ready drops once both entries are occupied.
// Reset (rst_n low, synchronous) clears the shift-held flag, the queue, the
// sequencer state and the output valid flag.
// ----------------------------------------------------------------------------
module char_event_to_scancode_translator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cets_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cets_pkg::out_item_t out_item
);
  import cets_pkg::*;

  // Front to queue.
  logic       push_valid;
  cmd_t       push_cmd;
  q_status_t  q_status;

  // Queue to back.
  logic       pop_valid;
  logic       pop_ready;
  cmd_t       pop_cmd;
  bk_status_t bk_status;

  // The classifier accepts, classifies and updates the shift flag.
  cets_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  // Commands wait here until the sequencer is free.
  cets_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .status     (q_status)
  );

  // The sequencer expands each command into its result items.
  cets_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .status    (bk_status)
  );

  // The sequencer never runs past the third item of a run.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.phase != 2'd3)
    else $error("sequencer phase out of range");

  // Mid-run, the previous item of that run is still held or was just replaced.
  a_mid_run_output: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_status.phase != PH_FIRST) |-> (bk_status.busy && out_valid))
    else $error("run in progress without a pending result");

  // Input is stalled only because the queue is full.
  a_ready_means_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_status.full)
    else $error("input stalled with room in the queue");

  // A wrapped run that is not finished keeps the sequencer off the queue.
  a_no_pop_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_status.phase == PH_KEY) |-> !pop_ready)
    else $error("queue popped in the middle of a run");

endmodule

@@ design/cets_front.sv @@
// ----------------------------------------------------------------------------
// cets_front: event classifier
// Accepts input items, tracks the shift-held flag and turns each event into
// one command for the sequencer, or drops it.
// ----------------------------------------------------------------------------
module cets_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cets_pkg::in_item_t in_item,
  input  cets_pkg::q_status_t q_status,
  output logic               push_valid,
  output cets_pkg::cmd_t     push_cmd
);
  import cets_pkg::*;

  logic       shift_held_r;
  logic       shift_held_nxt;
  logic       accept;
  logic       down;
  logic       printable;
  logic       is_shift;
  logic [7:0] offset;
  logic [7:0] entry;
  special_t   spec;

  assign in_ready  = !q_status.full;
  assign accept    = in_valid && in_ready;
  assign down      = (in_item.event_state == EV_PRESS) || (in_item.event_state == EV_HOLD);
  assign printable = (in_item.key_code >= KC_PRINT_LO) && (in_item.key_code < KC_PRINT_HI);
  assign is_shift  = (in_item.key_code == KC_LSHIFT) || (in_item.key_code == KC_RSHIFT);
  assign offset    = in_item.key_code - KC_PRINT_LO;
  assign entry     = char_entry(offset[6:0]);
  assign spec      = map_special(in_item.key_code);

  always_comb begin
    push_cmd.down    = down;
    push_cmd.need    = entry[7];
    push_cmd.restore = shift_held_r;
    if (printable) begin
      push_cmd.scancode = entry[6:0];
      push_cmd.wrap     = down && (entry[7] != shift_held_r);
      push_valid        = accept;
    end else begin
      push_cmd.scancode = spec.code;
      push_cmd.wrap     = 1'b0;
      push_valid        = accept && spec.ok;
    end
  end

  always_comb begin
    shift_held_nxt = shift_held_r;
    if (accept && is_shift) begin
      shift_held_nxt = down;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_held_r <= 1'b0;
    end else begin
      shift_held_r <= shift_held_nxt;
    end
  end

endmodule

@@ design/cets_queue.sv @@
// ----------------------------------------------------------------------------
// cets_queue: two-entry command queue
// Decouples the classifier from the sequencer so each side stalls alone.
// ----------------------------------------------------------------------------
module cets_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  cets_pkg::cmd_t      push_cmd,
  output logic                pop_valid,
  input  logic                pop_ready,
  output cets_pkg::cmd_t      pop_cmd,
  output cets_pkg::q_status_t status
);
  import cets_pkg::*;

  cmd_t       mem_r [0:1];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign status.full  = (cnt_r == 2'd2);
  assign status.empty = (cnt_r == 2'd0);
  assign pop_valid    = !status.empty;
  assign pop_cmd      = mem_r[rptr_r];
  assign do_push      = push_valid && !status.full;
  assign do_pop       = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ design/cets_back.sv @@
// ----------------------------------------------------------------------------
// cets_back: result sequencer
// Expands each command into one result, or into the three results of a
// shift-wrapped key, and holds them in the output register.
// ----------------------------------------------------------------------------
module cets_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  cets_pkg::cmd_t       pop_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cets_pkg::out_item_t  out_item,
  output cets_pkg::bk_status_t status
);
  import cets_pkg::*;

  cmd_t       cmd_r;
  logic       busy_r, busy_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;
  out_item_t  cur_item;
  logic       load;
  logic       last;

  always_comb begin
    cur_item = '{key_down: cmd_r.down, out_keycode: cmd_r.scancode, last_of_run: 1'b1};
    if (cmd_r.wrap) begin
      unique case (phase_r)
        PH_FIRST: cur_item = '{key_down: cmd_r.need, out_keycode: SC_SHIFT, last_of_run: 1'b0};
        PH_KEY:   cur_item = '{key_down: 1'b1, out_keycode: cmd_r.scancode, last_of_run: 1'b0};
        default:  cur_item = '{key_down: cmd_r.restore, out_keycode: SC_SHIFT,
                               last_of_run: 1'b1};
      endcase
    end
  end

  assign last      = cur_item.last_of_run;
  assign load      = busy_r && (!out_valid_r || out_ready);
  assign pop_ready = !busy_r || (load && last);

  always_comb begin
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      phase_nxt     = phase_r + 2'd1;
      if (last) begin
        busy_nxt  = 1'b0;
        phase_nxt = PH_FIRST;
      end
    end
    if (pop_valid && pop_ready) begin
      busy_nxt  = 1'b1;
      phase_nxt = PH_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cmd_r <= pop_cmd;
    end
    if (load) begin
      out_item_r <= cur_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;
  assign status.busy  = busy_r;
  assign status.phase = phase_r;

endmodule
